// File: rtl/core/ltr3_pkg.sv
package ltr3_pkg;

    localparam int unsigned DivSteps  = 17;
    localparam int unsigned RootSteps = 33;
    localparam logic [16:0] UnitOne   = 17'd65536;
    localparam logic [30:0] SpeedInit = 31'd65536;

    typedef struct packed {
        logic               req_type;
        logic        [31:0] elapsed_time;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               path_status;
    } t_res;

    typedef enum logic {
        REQ_EVAL     = 1'b0,
        REQ_RETARGET = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic mul_en;
        logic pos_en;
        logic dif_en;
        logic sq_en;
        logic div_load;
        logic div_step;
    } t_lane_ctrl;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               ovf;
        logic signed [17:0] u;
        logic        [63:0] sq;
    } t_lane_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_MUL,
        S_POS,
        S_MERGE,
        S_DIFF,
        S_SQ,
        S_SUM,
        S_RSTART,
        S_ROOT,
        S_DINIT,
        S_DIV,
        S_UPD
    } t_state;

endpackage

// File: rtl/core/ltr3_lane.sv
module ltr3_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ltr3_pkg::t_lane_ctrl  i_ctrl,
    input  logic           [30:0] i_speed,
    input  logic           [46:0] i_dist,
    input  logic signed    [31:0] i_start,
    input  logic signed    [31:0] i_end,
    input  logic signed    [17:0] i_u,
    input  logic           [32:0] i_norm,
    output ltr3_pkg::t_lane_res   o_res
);
    import ltr3_pkg::*;

    logic        [47:0] r_mv;
    logic        [63:0] r_ms;
    logic               r_neg;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic               r_ovf;
    logic        [31:0] r_mag;
    logic               r_dneg;
    logic        [63:0] r_sq;
    logic        [32:0] r_rem;
    logic        [16:0] r_quo;

    logic        [16:0] w_m;
    logic        [48:0] w_vsum;
    logic        [31:0] w_v;
    logic        [64:0] w_osum;
    logic signed [34:0] w_off;
    logic signed [34:0] w_pos;
    logic signed [32:0] w_d;
    logic        [48:0] w_num;
    logic        [33:0] w_trial;
    logic               w_ge;
    logic        [16:0] w_qc;

    assign w_m     = i_u[17] ? 17'(-i_u) : i_u[16:0];
    assign w_vsum  = {1'b0, r_mv} + 49'd32768;
    assign w_v     = w_vsum[47:16];
    assign w_osum  = {1'b0, r_ms} + 65'd32768;
    assign w_off   = {1'b0, w_osum[49:16]};
    assign w_pos   = r_neg ? 35'(i_start) - w_off : 35'(i_start) + w_off;
    assign w_d     = 33'(i_end) - 33'(i_start);
    assign w_num   = {1'b0, r_mag, 16'd0} + {16'd0, i_norm[32:1]};
    assign w_trial = {r_rem, r_quo[16]};
    assign w_ge    = w_trial >= {1'b0, i_norm};
    assign w_qc    = (r_quo > UnitOne) ? UnitOne : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_mv  <= w_m * i_speed;
            r_ms  <= w_m * i_dist;
            r_neg <= i_u[17];
        end
        if (i_ctrl.pos_en) begin
            r_pos <= w_pos[31:0];
            r_vel <= r_neg ? -w_v : w_v;
        end
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (i_ctrl.pos_en) begin
            r_ovf <= (w_pos[34:31] != 4'b0000) && (w_pos[34:31] != 4'b1111);
        end
        if (i_ctrl.dif_en) begin
            r_dneg <= w_d[32];
            r_mag  <= w_d[32] ? 32'(-w_d) : w_d[31:0];
        end
        if (i_ctrl.sq_en) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_ctrl.div_load) begin
            r_rem <= {1'b0, w_num[48:17]};
            r_quo <= w_num[16:0];
        end else if (i_ctrl.div_step) begin
            r_rem <= w_ge ? 33'(w_trial - {1'b0, i_norm}) : w_trial[32:0];
            r_quo <= {r_quo[15:0], w_ge};
        end
    end

    assign o_res.pos = r_pos;
    assign o_res.vel = r_vel;
    assign o_res.ovf = r_ovf;
    assign o_res.u   = r_dneg ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
    assign o_res.sq  = r_sq;

endmodule

// File: rtl/core/ltr3_sqrt.sv
module ltr3_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_value,
    output logic [32:0] o_root,
    output logic        o_done
);
    import ltr3_pkg::*;

    logic [65:0] r_val;
    logic [34:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [36:0] w_t;
    logic [36:0] w_trial;
    logic        w_ge;

    assign w_t     = {r_rem, r_val[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 6'(RootSteps - 1));
            if (i_start) begin
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? 35'(w_t - w_trial) : w_t[34:0];
                r_root <= {r_root[31:0], w_ge};
                r_val  <= {r_val[63:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(RootSteps - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// File: rtl/core/linear_trajectory_3d_top.sv
// Constant-speed straight-line path generator, three axes, Q16.16.
// Input channel (i_in_valid/o_in_ready, payload i_in) carries one request:
// evaluate returns position, velocity and status at the elapsed time;
// retarget evaluates at its time, restarts the segment from that point
// toward the new target and returns nothing.
// Output channel (o_out_valid/i_out_ready, payload o_out) holds one result
// in an output register until taken.
// One request at a time: o_in_ready is high only while the sequencer idles.
// Evaluate: the request passes the product, multiply and position steps to
// the merge step, which loads the output register once it is free and idles.
// Retarget: lanes square the axis differences; a 33-step square root of the
// squared length and a 17-step quotient per axis lane give the unit direction.
// If the receiver stalls, a finished evaluate waits in the merge step and
// no further request is taken until the output register frees up.
// i_cfg_we writes max_speed (i_cfg_wdata) at once; write only while idle.
// Synchronous reset: segment at the origin, zero direction, max_speed
// 1.0, output empty.
module linear_trajectory_3d_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ltr3_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ltr3_pkg::t_res  o_out,
    input  logic            i_cfg_we,
    input  logic     [30:0] i_cfg_wdata
);
    import ltr3_pkg::*;

    t_state             r_state, n_state;
    logic        [30:0] r_speed;
    logic signed [31:0] r_start [3];
    logic signed [31:0] r_end   [3];
    logic signed [17:0] r_u     [3];
    logic        [32:0] r_norm;
    t_req               r_req;
    logic        [62:0] r_prod;
    logic               r_act;
    logic        [65:0] r_sum;
    logic        [4:0]  r_cnt;
    t_res               r_out;
    logic               r_out_valid;

    t_lane_ctrl         w_ctrl;
    t_lane_res          w_lane [3];
    logic        [62:0] w_prod;
    logic               w_status;
    logic signed [31:0] w_rpos [3];
    logic signed [31:0] w_rvel [3];
    logic               w_out_free;
    logic               w_out_load;
    logic        [32:0] w_root;
    logic               w_root_done;
    logic               w_root_start;
    logic signed [31:0] w_tgt  [3];

    assign w_prod     = r_req.elapsed_time * r_speed;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_MERGE) && (r_req.req_type == REQ_EVAL) && w_out_free;
    assign w_status   = !r_act || w_lane[0].ovf || w_lane[1].ovf || w_lane[2].ovf;
    assign w_tgt[0]   = r_req.target_x;
    assign w_tgt[1]   = r_req.target_y;
    assign w_tgt[2]   = r_req.target_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign w_rpos[g] = w_status ? r_end[g] : w_lane[g].pos;
        assign w_rvel[g] = w_status ? 32'sd0 : w_lane[g].vel;

        ltr3_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_speed (r_speed),
            .i_dist  (r_prod[62:16]),
            .i_start (r_start[g]),
            .i_end   (r_end[g]),
            .i_u     (r_u[g]),
            .i_norm  (r_norm),
            .o_res   (w_lane[g])
        );
    end

    ltr3_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_sum),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    always_comb begin
        n_state      = r_state;
        w_ctrl       = '0;
        w_root_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PROD;
            end
            S_PROD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                w_ctrl.mul_en = 1'b1;
                n_state       = S_POS;
            end
            S_POS: begin
                w_ctrl.pos_en = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                if (r_req.req_type == REQ_RETARGET) begin
                    n_state = S_DIFF;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                w_ctrl.dif_en = 1'b1;
                n_state       = S_SQ;
            end
            S_SQ: begin
                w_ctrl.sq_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                n_state = S_RSTART;
            end
            S_RSTART: begin
                w_root_start = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_done) n_state = S_DINIT;
            end
            S_DINIT: begin
                w_ctrl.div_load = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                w_ctrl.div_step = 1'b1;
                if (r_cnt == 5'(DivSteps - 1)) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= SpeedInit;
            r_norm      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_u[i]     <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_speed <= i_cfg_wdata;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_req <= i_in;
                end
                S_PROD: begin
                    r_prod <= w_prod;
                end
                S_MUL: begin
                    r_act <= {1'b0, r_prod} < {15'd0, r_norm, 16'd0};
                end
                S_MERGE: begin
                    if (r_req.req_type == REQ_RETARGET) begin
                        for (int i = 0; i < 3; i++) begin
                            r_start[i] <= w_rpos[i];
                            r_end[i]   <= w_tgt[i];
                        end
                    end else if (w_out_free) begin
                        r_out.pos_x       <= w_rpos[0];
                        r_out.pos_y       <= w_rpos[1];
                        r_out.pos_z       <= w_rpos[2];
                        r_out.vel_x       <= w_rvel[0];
                        r_out.vel_y       <= w_rvel[1];
                        r_out.vel_z       <= w_rvel[2];
                        r_out.path_status <= w_status;
                    end
                end
                S_SUM: begin
                    r_sum <= {2'b00, w_lane[0].sq} + {2'b00, w_lane[1].sq}
                           + {2'b00, w_lane[2].sq};
                end
                S_ROOT: begin
                    if (w_root_done) r_norm <= w_root;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                end
                S_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_u[i] <= (r_norm == '0) ? 18'sd0 : w_lane[i].u;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/ltr3_check.sv
module ltr3_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ltr3_pkg::t_res o_out
);
    import ltr3_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result changed under stall");

    a_expired_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.path_status |->
            o_out.vel_x == 0 && o_out.vel_y == 0 && o_out.vel_z == 0)
        else $error("expired result with nonzero velocity");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

endmodule

bind linear_trajectory_3d_top ltr3_check u_ltr3_check (.*);

// File: test/linear_trajectory_3d_top_tb.sv
module linear_trajectory_3d_top_tb;
    import ltr3_pkg::*;

    class traj_scoreboard;
        t_res        expected_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned retargets;
        int unsigned expired_seen;
        logic [30:0] speed;
        longint      seg_start[3];
        longint      seg_end[3];
        longint      dir[3];

        function new();
            speed = SpeedInit;
            for (int i = 0; i < 3; i++) begin
                seg_start[i] = 0;
                seg_end[i]   = 0;
                dir[i]       = 0;
            end
        endfunction

        function automatic logic [63:0] seg_norm();
            logic [127:0] acc;
            logic [127:0] cand;
            logic [63:0]  m;
            logic [63:0]  r;
            acc = 0;
            r   = 0;
            for (int i = 0; i < 3; i++) begin
                m   = (seg_end[i] < seg_start[i]) ? seg_start[i] - seg_end[i]
                                                  : seg_end[i] - seg_start[i];
                acc = acc + 128'(m) * 128'(m);
            end
            for (int b = 34; b >= 0; b--) begin
                cand = 128'(r | (64'd1 << b));
                if (cand * cand <= acc)
                    r = r | (64'd1 << b);
            end
            return r;
        endfunction

        function automatic bit path_at(input logic [31:0] t, output longint pos[3],
                                       output longint vel[3]);
            logic [63:0] norm;
            logic [63:0] prod;
            logic [63:0] travel;
            logic [63:0] m;
            logic [63:0] v;
            logic [63:0] off;
            bit          active;
            norm   = seg_norm();
            prod   = 64'(t) * 64'(speed);
            active = prod < (norm << 16);
            if (active) begin
                travel = prod >> 16;
                for (int i = 0; i < 3; i++) begin
                    m   = (dir[i] < 0) ? -dir[i] : dir[i];
                    v   = (m * 64'(speed) + 64'd32768) >> 16;
                    off = (m * travel + 64'd32768) >> 16;
                    vel[i] = (dir[i] < 0) ? -longint'(v) : longint'(v);
                    pos[i] = seg_start[i] + ((dir[i] < 0) ? -longint'(off) : longint'(off));
                    if (pos[i] > 64'sd2147483647 || pos[i] < -64'sd2147483648)
                        active = 0;
                end
            end
            if (!active) begin
                for (int i = 0; i < 3; i++) begin
                    pos[i] = seg_end[i];
                    vel[i] = 0;
                end
            end
            return !active;
        endfunction

        function void note_request(input t_req req);
            longint      pos[3];
            longint      vel[3];
            longint      tgt[3];
            logic [63:0] norm;
            logic [63:0] mag;
            logic [63:0] q;
            bit          expired;
            t_res        res;
            expired = path_at(req.elapsed_time, pos, vel);
            if (req.req_type == REQ_EVAL) begin
                res.pos_x       = pos[0][31:0];
                res.pos_y       = pos[1][31:0];
                res.pos_z       = pos[2][31:0];
                res.vel_x       = vel[0][31:0];
                res.vel_y       = vel[1][31:0];
                res.vel_z       = vel[2][31:0];
                res.path_status = expired;
                expected_q.push_back(res);
                return;
            end
            retargets++;
            tgt[0] = longint'(req.target_x);
            tgt[1] = longint'(req.target_y);
            tgt[2] = longint'(req.target_z);
            for (int i = 0; i < 3; i++) begin
                seg_start[i] = pos[i];
                seg_end[i]   = tgt[i];
            end
            norm = seg_norm();
            for (int i = 0; i < 3; i++) begin
                if (norm == 0) begin
                    dir[i] = 0;
                end else begin
                    mag = (seg_end[i] < seg_start[i]) ? seg_start[i] - seg_end[i]
                                                      : seg_end[i] - seg_start[i];
                    q   = ((mag << 16) + (norm >> 1)) / norm;
                    if (q > 64'd65536)
                        q = 64'd65536;
                    dir[i] = (seg_end[i] < seg_start[i]) ? -longint'(q) : longint'(q);
                end
            end
        endfunction

        function void check_result(input t_res got);
            t_res exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (exp_res.path_status)
                expired_seen++;
            if (got.pos_x !== exp_res.pos_x || got.pos_y !== exp_res.pos_y ||
                got.pos_z !== exp_res.pos_z || got.vel_x !== exp_res.vel_x ||
                got.vel_y !== exp_res.vel_y || got.vel_z !== exp_res.vel_z ||
                got.path_status !== exp_res.path_status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %0d: expected pos %h %h %h vel %h %h %h st %b, got pos %h %h %h vel %h %h %h st %b",
                             checked, exp_res.pos_x, exp_res.pos_y, exp_res.pos_z,
                             exp_res.vel_x, exp_res.vel_y, exp_res.vel_z,
                             exp_res.path_status, got.pos_x, got.pos_y, got.pos_z,
                             got.vel_x, got.vel_y, got.vel_z, got.path_status);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    t_req        i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    t_res        o_out;
    logic        i_cfg_we = 0;
    logic [30:0] i_cfg_wdata = '0;

    traj_scoreboard sb = new();
    int unsigned    cycles = 0;
    int unsigned    burst_left = 0;
    int unsigned    stall_mode = 0;
    int unsigned    stall_left = 0;
    int unsigned    n_sent = 0;

    linear_trajectory_3d_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("linear_trajectory_3d_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out);
        end
    end

    // receiver: drive i_out_ready from one of four randomly chosen stall patterns
    always @(posedge i_clk) begin
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: begin
                if (stall_left == 0) begin
                    stall_left  <= $urandom_range(1, 25);
                    i_out_ready <= ~i_out_ready;
                end else begin
                    stall_left <= stall_left - 1;
                end
            end
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_req(input t_req req);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic set_speed(input logic [30:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.speed = v;
    endtask

    function automatic t_req make_req(input t_req_kind kind, input logic [31:0] t,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
        t_req r;
        r.req_type     = kind;
        r.elapsed_time = t;
        r.target_x     = x;
        r.target_y     = y;
        r.target_z     = z;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(input int axis);
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            1: return $urandom;
            2: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            3: return sb.seg_end[axis][31:0];
            default: return sb.seg_end[axis][31:0] + $urandom_range(0, 32'h40000) - 32'h20000;
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        logic [63:0] t_end;
        t_end = (sb.seg_norm() << 16) / sb.speed;
        t_end = t_end + (t_end >> 2) + 1;
        if ($urandom_range(0, 9) == 0 || t_end > 64'hFFFF_FFFF)
            return $urandom;
        return $urandom_range(0, t_end[31:0]);
    endfunction

    logic [30:0] speeds[8];

    initial begin
        speeds = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'h2000, 31'h0008_0000,
                   31'd300, 31'h0100_0000, 31'd65536};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(make_req(REQ_EVAL, 32'd0, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'hFFFF_FFFF, 0, 0, 0));
        send_req(make_req(REQ_RETARGET, 32'd0, 32'h0001_0000, 0, 0));
        send_req(make_req(REQ_EVAL, 32'd0, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'h0000_8000, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'h0001_0000, 0, 0, 0));
        send_req(make_req(REQ_RETARGET, 32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF));
        send_req(make_req(REQ_EVAL, 32'h0100_0000, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'hFFFF_FFFF, 0, 0, 0));
        send_req(make_req(REQ_RETARGET, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000));
        send_req(make_req(REQ_EVAL, 32'h7FFF_FFFF, 0, 0, 0));
        send_req(make_req(REQ_RETARGET, 32'h0010_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000));
        send_req(make_req(REQ_EVAL, 32'd1, 0, 0, 0));
        set_speed(31'h7FFF_FFFF);
        send_req(make_req(REQ_RETARGET, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF));
        send_req(make_req(REQ_EVAL, 32'h0000_0100, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'h0001_0000, 0, 0, 0));
        set_speed(31'd1);
        send_req(make_req(REQ_RETARGET, 32'd0, 0, 0, 32'h0000_0001));
        send_req(make_req(REQ_EVAL, 32'hFFFF_FFFF, 0, 0, 0));
        send_req(make_req(REQ_EVAL, 32'h0000_FFFF, 0, 0, 0));

        foreach (speeds[k]) begin
            set_speed((k == 4) ? 31'($urandom_range(1, 32'h7FFF_FFFF)) : speeds[k]);
            repeat (245) begin
                if ($urandom_range(0, 4) == 0)
                    send_req(make_req(REQ_RETARGET, rand_time(), rand_coord(0),
                                      rand_coord(1), rand_coord(2)));
                else if ($urandom_range(0, 15) == 0)
                    send_req(make_req(t_req_kind'($urandom_range(0, 1)), $urandom,
                                      $urandom, $urandom, $urandom));
                else
                    send_req(make_req(REQ_EVAL, rand_time(), $urandom, $urandom, $urandom));
            end
        end

        drain();
        $display("sent %0d requests (%0d retargets), checked %0d results, %0d expired",
                 n_sent, sb.retargets, sb.checked, sb.expired_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("linear_trajectory_3d_top regression: pass");
        else
            $display("linear_trajectory_3d_top regression: fail");
        $finish;
    end

endmodule
